// ===== design/mac_address_learning_table_top_defines.svh =====
// Assertion macros shared by the station address table design.
`ifndef MAC_ADDRESS_LEARNING_TABLE_TOP_DEFINES_SVH
`define MAC_ADDRESS_LEARNING_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check cons in the same cycle whenever ante holds.
`define MALT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante holds.
`define MALT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MALT_ASSERT_NOW(lbl, ante, cons)
`define MALT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/malt_pkg.sv =====
// Shared constants, status codes and the address byte sum for the station address table.
package malt_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int ADDR_W         = 48;
  localparam int ADDR_BYTES     = 6;
  localparam int BYTE_W         = 8;
  localparam int SUM_W          = 11;  // six bytes of 255 sum to 1530
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 6;
  localparam int GROUP_BIT      = 40;  // I/G bit of the first byte

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT       = 3'd0,
    STAT_MISS      = 3'd1,
    STAT_INSERTED  = 3'd2,
    STAT_OVERWROTE = 3'd3,
    STAT_GROUP     = 3'd4
  } status_t;

  function automatic logic [SUM_W-1:0] byte_sum(input logic [ADDR_W-1:0] a);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int b = 0; b < ADDR_BYTES; b++) begin
      s = s + SUM_W'(a[b*BYTE_W +: BYTE_W]);
    end
    return s;
  endfunction

endpackage

// ===== design/malt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module malt_ram #(
  parameter int WIDTH = malt_pkg::ADDR_W,
  parameter int DEPTH = malt_pkg::TABLE_SIZE_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/malt_hash.sv =====
// Home slot unit: byte sum of the address, then the remainder by reciprocal multiplication.
module malt_hash #(
  parameter int TABLE_SIZE = malt_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [malt_pkg::ADDR_W-1:0] addr,
  output logic                       done,
  output logic [IDX_W-1:0]           home
);

  localparam int     SUM_W   = malt_pkg::SUM_W;
  // floor(sum / TABLE_SIZE) equals (sum * RECIP) >> SHIFT for every sum below 2**SUM_W.
  localparam int     SHIFT   = SUM_W + $clog2(TABLE_SIZE);
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam int     RCP_W   = $clog2(RECIP_L + 1);
  localparam int     PROD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RECIP_L);
  // Quotient times divisor never exceeds the sum, so its low bits are enough.
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(TABLE_SIZE);

  logic              stg1_r;
  logic              stg2_r;
  logic              done_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  quo_r;
  logic [SUM_W-1:0]  quo_nxt;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  rem_nxt;
  logic [PROD_W-1:0] prod;

  always_comb begin
    prod    = PROD_W'(sum_r) * PROD_W'(RECIP);
    quo_nxt = SUM_W'(prod >> SHIFT);
    rem_nxt = sum_r - quo_r * DIVISOR;
  end

  // Advance the stages in order: sum, quotient, remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      stg2_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg1_r <= start;
      stg2_r <= stg1_r;
      done_r <= stg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= malt_pkg::byte_sum(addr);
    end
    if (stg1_r) begin
      quo_r <= quo_nxt;
    end
    if (stg2_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign home = IDX_W'(rem_r);

endmodule

// ===== design/mac_address_learning_table_top.sv =====
// Top level of the station address learning table: sequencer around the address RAM.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_req_type (1), in_mac_addr (48)
//  out_     output     out_valid/out_stall  out_status (3), out_slot (6)
//
// Accepted beat: the home slot comes from byte sum, reciprocal multiply and
// subtract; the probe reads from the home slot up to the last slot (a hit stops
// early); a learn that inserts or overwrites then writes its slot, and the result
// is loaded. A group learn skips the table and goes straight to the result.
// After reset the table is cleared one slot a cycle, in_stall high.
// A stalled result holds while the next beat is taken; a new result waits for it.
`include "mac_address_learning_table_top_defines.svh"

module mac_address_learning_table_top #(
  parameter int TABLE_SIZE = malt_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [malt_pkg::ADDR_W-1:0]   in_mac_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [malt_pkg::STATUS_W-1:0] out_status,
  output logic [malt_pkg::SLOT_W-1:0]   out_slot
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int ADDR_W = malt_pkg::ADDR_W;
  localparam int SLOT_W = malt_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] END_IDX   = CNT_W'(TABLE_SIZE);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic                  req_r, req_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [IDX_W-1:0]      home_r, home_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                  emp_vld_r, emp_vld_nxt;
  logic [IDX_W-1:0]      emp_idx_r, emp_idx_nxt;
  logic [IDX_W-1:0]      wr_idx_r, wr_idx_nxt;
  malt_pkg::status_t     res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  malt_pkg::status_t     out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [ADDR_W-1:0]     ram_wr_data;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  logic [ADDR_W-1:0]     ram_rd_data;

  logic                  hash_start;
  logic                  hash_done;
  logic [IDX_W-1:0]      hash_home;

  // Slot just read is empty, and the first empty slot of the probe so far.
  logic                  emp_here;
  logic                  emp_any;
  logic [IDX_W-1:0]      emp_first;

  assign emp_here  = (ram_rd_data == '0);
  assign emp_any   = emp_vld_r || emp_here;
  assign emp_first = emp_vld_r ? emp_idx_r : chk_idx_r;

  malt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  malt_hash #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .addr  (addr_nxt),
    .done  (hash_done),
    .home  (hash_home)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    home_nxt       = home_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    emp_vld_nxt    = emp_vld_r;
    emp_idx_nxt    = emp_idx_r;
    wr_idx_nxt     = wr_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = wr_idx_r;
    ram_wr_data    = addr_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = rd_idx_r[IDX_W-1:0];
    hash_start     = 1'b0;

    // Drop the result once its beat is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Sweep zeros through the table, one slot a cycle.
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        ram_wr_data = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          addr_nxt = in_mac_addr;
          if (!in_req_type && in_mac_addr[malt_pkg::GROUP_BIT]) begin
            // Group address on a learn: skip the table altogether.
            res_status_nxt = malt_pkg::STAT_GROUP;
            res_slot_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          home_nxt    = hash_home;
          rd_idx_nxt  = CNT_W'(hash_home);
          emp_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next read while checking the data of the previous one.
        if (rd_idx_r < END_IDX) begin
          ram_rd_en  = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        chk_vld_nxt = ram_rd_en;
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (chk_vld_r) begin
          if (ram_rd_data == addr_r) begin
            res_status_nxt = malt_pkg::STAT_HIT;
            res_slot_nxt   = SLOT_W'(chk_idx_r);
            state_nxt      = ST_DONE;
          end else begin
            if (emp_here && !emp_vld_r) begin
              emp_vld_nxt = 1'b1;
              emp_idx_nxt = chk_idx_r;
            end
            if (chk_idx_r == LAST_SLOT) begin
              if (req_r) begin
                res_status_nxt = malt_pkg::STAT_MISS;
                res_slot_nxt   = '0;
                state_nxt      = ST_DONE;
              end else if (emp_any) begin
                wr_idx_nxt     = emp_first;
                res_status_nxt = malt_pkg::STAT_INSERTED;
                res_slot_nxt   = SLOT_W'(emp_first);
                state_nxt      = ST_WRITE;
              end else begin
                wr_idx_nxt     = home_r;
                res_status_nxt = malt_pkg::STAT_OVERWROTE;
                res_slot_nxt   = SLOT_W'(home_r);
                state_nxt      = ST_WRITE;
              end
            end
          end
        end
      end
      ST_WRITE: begin
        ram_wr_en = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Load the output register only once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      emp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      emp_vld_r   <= emp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    home_r       <= home_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    emp_idx_r    <= emp_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  // An accepted beat always starts work.
  `MALT_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != ST_IDLE)
  // A new result appears only from the result-loading step.
  `MALT_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE)
  // Results carry a defined status code.
  `MALT_ASSERT_NOW(a_status_code, out_valid_r, out_status_r <= malt_pkg::STAT_GROUP)

endmodule
